// ===== rtl/core/vcpc_pkg.sv =====
package vcpc_pkg;

   localparam int unsigned VID_W   = 20;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OFS_W   = 20;
   localparam int unsigned CNT_W   = 7;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_REGULAR = 2'd0,
      KIND_MINIMUM = 2'd1,
      KIND_SADDLE  = 2'd2,
      KIND_MAXIMUM = 2'd3
   } kind_type;

   typedef struct packed {
      logic [VID_W-1:0]          vertex_id;
      logic signed [VALUE_W-1:0] centre_value;
      logic [OFS_W-1:0]          centre_offset;
      logic signed [VALUE_W-1:0] neighbour_value;
      logic [OFS_W-1:0]          neighbour_offset;
      logic                      on_boundary;
      logic                      first_neighbour;
      logic                      last_neighbour;
   } req_type;

   typedef struct packed {
      logic [VID_W-1:0] vertex_index;
      kind_type         vertex_kind;
      logic [CNT_W-1:0] saddle_multiplicity;
      logic [CNT_W-1:0] sign_changes;
   } rsp_type;

   // One neighbour after comparison with the centre.
   typedef struct packed {
      logic [VID_W-1:0] vertex_id;
      logic             is_lower;
      logic             is_upper;
      logic             on_boundary;
      logic             first_neighbour;
      logic             last_neighbour;
   } cls_type;

endpackage

// ===== rtl/core/vcpc_front.sv =====
module vcpc_front (
   input  vcpc_pkg::req_type req_data,
   output vcpc_pkg::cls_type cls
);

   logic nb_below;
   logic nb_above;

   // Value decides first, offset breaks ties.
   always_comb begin
      nb_below = (req_data.neighbour_value < req_data.centre_value) ||
                 ((req_data.neighbour_value == req_data.centre_value) &&
                  (req_data.neighbour_offset < req_data.centre_offset));
      nb_above = (req_data.centre_value < req_data.neighbour_value) ||
                 ((req_data.neighbour_value == req_data.centre_value) &&
                  (req_data.centre_offset < req_data.neighbour_offset));
   end

   assign cls.vertex_id       = req_data.vertex_id;
   assign cls.is_lower        = nb_below;
   assign cls.is_upper        = nb_above;
   assign cls.on_boundary     = req_data.on_boundary;
   assign cls.first_neighbour = req_data.first_neighbour;
   assign cls.last_neighbour  = req_data.last_neighbour;

endmodule

// ===== rtl/core/vcpc_queue.sv =====
module vcpc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vcpc_pkg::cls_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output vcpc_pkg::cls_type pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

   vcpc_pkg::cls_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_DEPTH);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/vcpc_back.sv =====
module vcpc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cls_valid,
   input  vcpc_pkg::cls_type cls,
   output logic              cls_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vcpc_pkg::rsp_type rsp_data
);

   localparam int unsigned CW = vcpc_pkg::CNT_W;

   logic          no_lower_ff, no_lower_in;
   logic          no_higher_ff, no_higher_in;
   logic          prev_lower_ff, prev_lower_in;
   logic          first_lower_ff, first_lower_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   vcpc_pkg::rsp_type rsp_ff, rsp_in;

   logic          base_no_lower;
   logic          base_no_higher;
   logic          base_prev_lower;
   logic          base_first_lower;
   logic [CW-1:0] base_count;
   logic          nx_no_lower;
   logic          nx_no_higher;
   logic          nx_prev_lower;
   logic          nx_first_lower;
   logic [1:0]    bump;
   logic [CW:0]   count_sum;
   logic [CW-1:0] nx_count;
   logic [CW-1:0] half_count;
   vcpc_pkg::kind_type kind;
   logic [CW-1:0] mult;
   logic          out_free;

   // A non-last neighbour never waits on the result side.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cls_pop  = cls_valid && (!cls.last_neighbour || out_free);

   always_comb begin
      base_no_lower    = cls.first_neighbour ? 1'b1 : no_lower_ff;
      base_no_higher   = cls.first_neighbour ? 1'b1 : no_higher_ff;
      base_prev_lower  = cls.first_neighbour ? 1'b0 : prev_lower_ff;
      base_first_lower = cls.first_neighbour ? 1'b0 : first_lower_ff;
      base_count       = cls.first_neighbour ? '0 : count_ff;

      nx_no_lower    = base_no_lower;
      nx_no_higher   = base_no_higher;
      nx_prev_lower  = base_prev_lower;
      nx_first_lower = base_first_lower;
      bump           = 2'd0;

      if (cls.is_upper) begin
         nx_no_higher   = 1'b0;
         nx_first_lower = cls.first_neighbour ? 1'b0 : base_first_lower;
         nx_prev_lower  = 1'b0;
         bump = 2'(!cls.first_neighbour && base_prev_lower) +
                2'(cls.last_neighbour && nx_first_lower && !cls.on_boundary);
      end else if (cls.is_lower) begin
         nx_no_lower    = 1'b0;
         nx_first_lower = cls.first_neighbour ? 1'b1 : base_first_lower;
         nx_prev_lower  = 1'b1;
         bump = 2'(!cls.first_neighbour && !base_prev_lower) +
                2'(cls.last_neighbour && !nx_first_lower && !cls.on_boundary);
      end

      // Saturate the change counter.
      count_sum = {1'b0, base_count} + (CW+1)'(bump);
      nx_count  = count_sum[CW] ? vcpc_pkg::CNT_MAX : count_sum[CW-1:0];
   end

   always_comb begin
      half_count = nx_count >> 1;
      mult       = '0;
      if (nx_no_lower) begin
         kind = vcpc_pkg::KIND_MINIMUM;
      end else if (nx_no_higher) begin
         kind = vcpc_pkg::KIND_MAXIMUM;
      end else if (cls.on_boundary && nx_count == CW'(1)) begin
         kind = vcpc_pkg::KIND_REGULAR;
      end else if (!cls.on_boundary && nx_count == CW'(2)) begin
         kind = vcpc_pkg::KIND_REGULAR;
      end else begin
         kind = vcpc_pkg::KIND_SADDLE;
         if (cls.on_boundary) begin
            mult = (nx_count != '0) ? nx_count - 1'b1 : '0;
         end else begin
            mult = (half_count != '0) ? half_count - 1'b1 : '0;
         end
      end
   end

   always_comb begin
      no_lower_in    = no_lower_ff;
      no_higher_in   = no_higher_ff;
      prev_lower_in  = prev_lower_ff;
      first_lower_in = first_lower_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      if (cls_pop) begin
         if (cls.last_neighbour) begin
            // Close the ring and drop back to the empty state.
            no_lower_in    = 1'b1;
            no_higher_in   = 1'b1;
            prev_lower_in  = 1'b0;
            first_lower_in = 1'b0;
            count_in       = '0;
            rsp_valid_in   = 1'b1;
            rsp_in.vertex_index        = cls.vertex_id;
            rsp_in.vertex_kind         = kind;
            rsp_in.saddle_multiplicity = mult;
            rsp_in.sign_changes        = nx_count;
         end else begin
            no_lower_in    = nx_no_lower;
            no_higher_in   = nx_no_higher;
            prev_lower_in  = nx_prev_lower;
            first_lower_in = nx_first_lower;
            count_in       = nx_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         no_lower_ff    <= 1'b1;
         no_higher_ff   <= 1'b1;
         prev_lower_ff  <= 1'b0;
         first_lower_ff <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         no_lower_ff    <= no_lower_in;
         no_higher_ff   <= no_higher_in;
         prev_lower_ff  <= prev_lower_in;
         first_lower_ff <= first_lower_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/vertex_critical_point_classifier_unit.sv =====
// channel  | direction | signals                        | transfer when
// ---------+-----------+--------------------------------+-----------------------
// request  | in        | req_valid, req_stall, req_data | req_valid && !req_stall
// response | out       | rsp_valid, rsp_stall, rsp_data | rsp_valid && !rsp_stall
//
// One neighbour transfer per cycle while req_stall is low; the compare feeds the queue in
// the transfer cycle, and the ring accumulator takes one entry per cycle unless a
// last-neighbour entry waits on rsp_stall. The last neighbour is written into the queue
// behind any older entries, then the back stage registers the result and raises rsp_valid.
// reset is synchronous and active high; it empties the queue and clears the ring.
// req_stall rises only when the queue is full; rsp_stall holds back only
// last-neighbour entries, so earlier neighbours keep draining meanwhile.
module vertex_critical_point_classifier_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vcpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vcpc_pkg::rsp_type rsp_data
);

   vcpc_pkg::cls_type front_cls;
   vcpc_pkg::cls_type queue_head;
   logic              queue_full;
   logic              queue_not_empty;
   logic              queue_pop;

   // Front: compare each neighbour against the centre.
   vcpc_front u_front (
      .req_data (req_data),
      .cls      (front_cls)
   );

   // Queue decouples the request side from the result side.
   vcpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_cls),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_head)
   );

   assign req_stall = queue_full;

   // Back: accumulate the ring and register the vertex result.
   vcpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (queue_not_empty),
      .cls       (queue_head),
      .cls_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/vcpc_checker.sv =====
module vcpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input vcpc_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_mult_only_saddle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.vertex_kind != vcpc_pkg::KIND_SADDLE
      |-> rsp_data.saddle_multiplicity == '0)
      else $error("multiplicity on a non-saddle vertex");

   a_regular_changes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.vertex_kind == vcpc_pkg::KIND_REGULAR
      |-> rsp_data.sign_changes == 7'd1 || rsp_data.sign_changes == 7'd2)
      else $error("regular vertex with wrong change count");

   a_mult_below_changes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saddle_multiplicity != '0
      |-> rsp_data.sign_changes > rsp_data.saddle_multiplicity)
      else $error("multiplicity exceeds change count");

endmodule

bind vertex_critical_point_classifier_unit vcpc_checker u_vcpc_checker (.*);

// ===== dv/tb_vertex_critical_point_classifier_unit.sv =====
module tb_vertex_critical_point_classifier_unit;

   localparam int unsigned QUIET_LIMIT   = 3000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned SHOWN_ERRORS  = 10;

   localparam int unsigned VID_W   = vcpc_pkg::VID_W;
   localparam int unsigned VALUE_W = vcpc_pkg::VALUE_W;
   localparam int unsigned OFS_W   = vcpc_pkg::OFS_W;
   localparam int unsigned CNT_W   = vcpc_pkg::CNT_W;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [OFS_W-1:0]          OFS_MAX   = {OFS_W{1'b1}};
   localparam logic [VID_W-1:0]          VID_MAX   = {VID_W{1'b1}};

   // where a neighbour sits relative to the centre
   typedef enum int {
      NB_LOWER,
      NB_UPPER,
      NB_EQUAL
   } nb_side_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   vcpc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   vcpc_pkg::rsp_type rsp_data;

   vertex_critical_point_classifier_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Ring tracker: mirrors what the block accumulates over one star
   // ---------------------------------------------------------------------
   logic             ring_no_lower    = 1'b1;
   logic             ring_no_higher   = 1'b1;
   logic             ring_prev_lower  = 1'b0;
   logic             ring_first_lower = 1'b0;
   logic [CNT_W-1:0] ring_changes     = '0;

   vcpc_pkg::rsp_type expected_vertices[$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned burst_left     = 0;
   int unsigned neighbours_sent = 0;

   function automatic void clear_ring();
      ring_no_lower    = 1'b1;
      ring_no_higher   = 1'b1;
      ring_prev_lower  = 1'b0;
      ring_first_lower = 1'b0;
      ring_changes     = '0;
   endfunction

   function automatic void bump_changes();
      if (ring_changes != vcpc_pkg::CNT_MAX) ring_changes++;
   endfunction

   // Fold one accepted neighbour into the ring; on the last one, queue the
   // classification the block must produce and start a fresh ring.
   function automatic void classify_neighbour(input vcpc_pkg::req_type nb);
      logic              is_upper;
      logic              is_lower;
      vcpc_pkg::rsp_type verdict;
      if (nb.first_neighbour) clear_ring();
      // value decides first, the offset breaks ties
      is_upper = ($signed(nb.neighbour_value) > $signed(nb.centre_value)) ||
                 (nb.neighbour_value == nb.centre_value &&
                  nb.neighbour_offset > nb.centre_offset);
      is_lower = ($signed(nb.neighbour_value) < $signed(nb.centre_value)) ||
                 (nb.neighbour_value == nb.centre_value &&
                  nb.neighbour_offset < nb.centre_offset);
      if (is_upper) begin
         ring_no_higher = 1'b0;
         if (!nb.first_neighbour && ring_prev_lower) bump_changes();
         if (nb.first_neighbour) ring_first_lower = 1'b0;
         // close the ring for interior vertices
         if (nb.last_neighbour && ring_first_lower && !nb.on_boundary) bump_changes();
         ring_prev_lower = 1'b0;
      end else if (is_lower) begin
         ring_no_lower = 1'b0;
         if (!nb.first_neighbour && !ring_prev_lower) bump_changes();
         if (nb.first_neighbour) ring_first_lower = 1'b1;
         if (nb.last_neighbour && !ring_first_lower && !nb.on_boundary) bump_changes();
         ring_prev_lower = 1'b1;
      end
      // a neighbour equal to the centre leaves everything as it was
      if (!nb.last_neighbour) return;
      verdict.vertex_index        = nb.vertex_id;
      verdict.saddle_multiplicity = '0;
      verdict.sign_changes        = ring_changes;
      if (ring_no_lower) begin
         verdict.vertex_kind = vcpc_pkg::KIND_MINIMUM;
      end else if (ring_no_higher) begin
         verdict.vertex_kind = vcpc_pkg::KIND_MAXIMUM;
      end else if (nb.on_boundary && ring_changes == 1) begin
         verdict.vertex_kind = vcpc_pkg::KIND_REGULAR;
      end else if (!nb.on_boundary && ring_changes == 2) begin
         verdict.vertex_kind = vcpc_pkg::KIND_REGULAR;
      end else begin
         verdict.vertex_kind = vcpc_pkg::KIND_SADDLE;
         // clamp at zero when there are too few changes
         if (nb.on_boundary)
            verdict.saddle_multiplicity = (ring_changes != '0) ?
                                          ring_changes - 1'b1 : '0;
         else
            verdict.saddle_multiplicity = ((ring_changes >> 1) != '0) ?
                                          (ring_changes >> 1) - 1'b1 : '0;
      end
      expected_vertices.insert(expected_vertices.size(), verdict);
      clear_ring();
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   function automatic string show_vertex(input vcpc_pkg::rsp_type v);
      return $sformatf("index=%05h kind=%0d mult=%0d changes=%0d",
                       v.vertex_index, v.vertex_kind, v.saddle_multiplicity,
                       v.sign_changes);
   endfunction

   function automatic void note_mismatch(input string what, input string detail);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS)
         $display("mismatch %0d: %s: %s", mismatch_count, what, detail);
   endfunction

   // Compare each result transfer against the oldest outstanding vertex.
   always @(posedge clock) begin
      vcpc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_vertices.size() == 0) begin
            note_mismatch("unexpected result", show_vertex(rsp_data));
         end else begin
            want = expected_vertices.pop_front();
            if (rsp_data.vertex_index !== want.vertex_index ||
                rsp_data.vertex_kind !== want.vertex_kind ||
                rsp_data.saddle_multiplicity !== want.saddle_multiplicity ||
                rsp_data.sign_changes !== want.sign_changes)
               note_mismatch("wrong result",
                             {"expected ", show_vertex(want), " got ", show_vertex(rsp_data)});
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver back-pressure: switch between stall patterns now and then,
   // including stretches with no stall at all
   // ---------------------------------------------------------------------
   int unsigned stall_mode      = 0;
   int unsigned stall_mode_left = 0;
   int unsigned stall_phase     = 0;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_mode_left == 0) begin
         stall_mode      <= $urandom_range(0, 3);
         stall_mode_left <= $urandom_range(20, 300);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         2: rsp_stall <= (stall_phase % 7 < 3);
         default: rsp_stall <= ($urandom_range(0, 99) < 80);
      endcase
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run if nothing moves on either channel for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Send one neighbour and hold it until the transfer; the sender runs in
   // bursts, mostly with idle gaps between them.
   task automatic push_neighbour(input vcpc_pkg::req_type nb);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data  <= nb;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      neighbours_sent++;
      classify_neighbour(nb);
   endtask

   // Drop valid and wait until every queued vertex has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_vertices.size() != 0);
   endtask

   function automatic vcpc_pkg::req_type random_centre();
      vcpc_pkg::req_type nb;
      nb.vertex_id = VID_W'($urandom);
      case ($urandom_range(0, 7))
         0: nb.centre_value = ($urandom_range(0, 1) != 0) ? VALUE_MAX : VALUE_MIN;
         1: nb.centre_value = $signed($urandom_range(0, 8)) - 4;
         default: nb.centre_value = $urandom;
      endcase
      case ($urandom_range(0, 7))
         0: nb.centre_offset = ($urandom_range(0, 1) != 0) ? OFS_MAX : '0;
         default: nb.centre_offset = OFS_W'($urandom);
      endcase
      nb.neighbour_value  = nb.centre_value;
      nb.neighbour_offset = nb.centre_offset;
      nb.on_boundary      = 1'($urandom_range(0, 1));
      nb.first_neighbour  = 1'b0;
      nb.last_neighbour   = 1'b0;
      return nb;
   endfunction

   // Place the neighbour on the asked side of the centre, by value or by a
   // tie on value and a differing offset. Falls back to an equal neighbour
   // when the centre sits at the very end of the order.
   function automatic vcpc_pkg::req_type place_neighbour(input vcpc_pkg::req_type nb,
                                                         input nb_side_type side);
      longint cv;
      longint span;
      logic   by_value;
      cv = nb.centre_value;
      nb.neighbour_value  = nb.centre_value;
      nb.neighbour_offset = nb.centre_offset;
      case (side)
         NB_UPPER: begin
            by_value = (nb.centre_value != VALUE_MAX) &&
                       (nb.centre_offset == OFS_MAX || $urandom_range(0, 2) != 0);
            if (by_value) begin
               span = 64'sd2147483647 - cv;
               if ($urandom_range(0, 1) != 0)
                  nb.neighbour_value = VALUE_W'(cv + 1 + ($urandom % span));
               else
                  nb.neighbour_value = VALUE_W'(cv + 1 + ($urandom_range(0, 3) % span));
               nb.neighbour_offset = OFS_W'($urandom);
            end else if (nb.centre_offset != OFS_MAX) begin
               nb.neighbour_offset = OFS_W'(nb.centre_offset + 1 +
                                            ($urandom % (OFS_MAX - nb.centre_offset)));
            end
         end
         NB_LOWER: begin
            by_value = (nb.centre_value != VALUE_MIN) &&
                       (nb.centre_offset == '0 || $urandom_range(0, 2) != 0);
            if (by_value) begin
               span = cv + 64'sd2147483648;
               if ($urandom_range(0, 1) != 0)
                  nb.neighbour_value = VALUE_W'(cv - 1 - ($urandom % span));
               else
                  nb.neighbour_value = VALUE_W'(cv - 1 - ($urandom_range(0, 3) % span));
               nb.neighbour_offset = OFS_W'($urandom);
            end else if (nb.centre_offset != '0) begin
               nb.neighbour_offset = OFS_W'(nb.centre_offset - 1 -
                                            ($urandom % nb.centre_offset));
            end
         end
         default: ;
      endcase
      return nb;
   endfunction

   // Send a ring described by a string of L, U and E (lower, upper, equal).
   task automatic send_pattern(input string sides, input logic boundary,
                               input logic marked_first);
      vcpc_pkg::req_type centre;
      vcpc_pkg::req_type nb;
      nb_side_type       side;
      centre = random_centre();
      centre.on_boundary = boundary;
      for (int i = 0; i < sides.len(); i++) begin
         case (sides[i])
            "L": side = NB_LOWER;
            "U": side = NB_UPPER;
            default: side = NB_EQUAL;
         endcase
         nb = place_neighbour(centre, side);
         nb.first_neighbour = marked_first && (i == 0);
         nb.last_neighbour  = (i == sides.len() - 1);
         push_neighbour(nb);
      end
   endtask

   function automatic vcpc_pkg::req_type fixed_item(input logic [VID_W-1:0] vid,
                                          input logic signed [VALUE_W-1:0] c_value,
                                          input logic [OFS_W-1:0] c_offset,
                                          input logic signed [VALUE_W-1:0] n_value,
                                          input logic [OFS_W-1:0] n_offset,
                                          input logic boundary);
      vcpc_pkg::req_type nb;
      nb.vertex_id        = vid;
      nb.centre_value     = c_value;
      nb.centre_offset    = c_offset;
      nb.neighbour_value  = n_value;
      nb.neighbour_offset = n_offset;
      nb.on_boundary      = boundary;
      nb.first_neighbour  = 1'b1;
      nb.last_neighbour   = 1'b1;
      return nb;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Single-neighbour rings at the ends of the value and offset ranges.
   task automatic test_value_extremes();
      push_neighbour(fixed_item('0, VALUE_MIN, '0, VALUE_MAX, OFS_MAX, 1'b0));
      push_neighbour(fixed_item(VID_MAX, VALUE_MAX, OFS_MAX, VALUE_MIN, '0, 1'b1));
      push_neighbour(fixed_item(VID_MAX, VALUE_MAX, '0, VALUE_MAX, OFS_MAX, 1'b0));
      push_neighbour(fixed_item('0, VALUE_MIN, OFS_MAX, VALUE_MIN, '0, 1'b1));
      push_neighbour(fixed_item(20'h5a5a5, VALUE_MIN, OFS_MAX, VALUE_MIN, OFS_MAX, 1'b0));
   endtask

   // Regular and saddle rings, interior and boundary.
   task automatic test_vertex_kinds();
      send_pattern("LUU", 1'b0, 1'b1);
      send_pattern("LULU", 1'b0, 1'b1);
      send_pattern("LU", 1'b1, 1'b1);
      send_pattern("LUL", 1'b1, 1'b1);
   endtask

   // Equal neighbour inside a ring, and rings whose first marker is missing.
   task automatic test_special_cases();
      send_pattern("LEU", 1'b0, 1'b1);
      send_pattern("UL", 1'b0, 1'b0);
      send_pattern("EE", 1'b1, 1'b0);
   endtask

   // A long alternating ring pushes the change counter into saturation; a boundary ring follows.
   task automatic test_counter_saturation();
      string sides;
      sides = "";
      for (int i = 0; i < 140; i++) sides = {sides, (i % 2 == 0) ? "L" : "U"};
      send_pattern(sides, 1'b0, 1'b1);
      sides = "";
      for (int i = 0; i < 64; i++) sides = {sides, (i % 3 == 0) ? "U" : "L"};
      send_pattern(sides, 1'b1, 1'b1);
   endtask

   // Mostly well-formed rings with random content; a tenth are broken
   // sequences with random markers and unrelated fields.
   task automatic test_random_rings(input int unsigned budget);
      int unsigned       start;
      int unsigned       degree;
      int unsigned       upper_pct;
      vcpc_pkg::req_type centre;
      vcpc_pkg::req_type nb;
      nb_side_type       side;
      start = neighbours_sent;
      while (neighbours_sent - start < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            degree = $urandom_range(1, 4);
            for (int i = 0; i < degree; i++) begin
               nb.vertex_id        = VID_W'($urandom);
               nb.centre_value     = $urandom;
               nb.centre_offset    = OFS_W'($urandom);
               nb.neighbour_value  = $urandom;
               nb.neighbour_offset = OFS_W'($urandom);
               nb.on_boundary      = 1'($urandom_range(0, 1));
               nb.first_neighbour  = 1'($urandom_range(0, 1));
               nb.last_neighbour   = 1'($urandom_range(0, 1));
               push_neighbour(nb);
            end
         end else begin
            case ($urandom_range(0, 19))
               0:       degree = $urandom_range(25, 64);
               1, 2, 3: degree = $urandom_range(9, 24);
               default: degree = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 3))
               0: upper_pct = 0;
               1: upper_pct = 100;
               2: upper_pct = 50;
               default: upper_pct = $urandom_range(0, 100);
            endcase
            centre = random_centre();
            for (int i = 0; i < degree; i++) begin
               if ($urandom_range(0, 9) == 0)
                  side = NB_EQUAL;
               else
                  side = ($urandom_range(1, 100) <= upper_pct) ? NB_UPPER : NB_LOWER;
               nb = place_neighbour(centre, side);
               nb.first_neighbour = (i == 0);
               nb.last_neighbour  = (i == degree - 1);
               push_neighbour(nb);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_value_extremes();
      test_vertex_kinds();
      test_special_cases();
      // let the sender wait for all results at least once
      hold_until_drained();
      test_counter_saturation();
      test_random_rings(400);
      hold_until_drained();
      test_random_rings(350);

      req_valid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
